### sv/frame_ring_queue_defines.svh
// Assertion helpers for the frame ring queue RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef FRAME_RING_QUEUE_DEFINES_SVH
`define FRAME_RING_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRQ_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame_ring_queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FRQ_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame_ring_queue: next-cycle check failed");

`endif

### sv/frq_pkg.sv
package frq_pkg;

	// Default sizes of the ring.
	localparam int QUEUE_SLOTS_DEF = 16;
	localparam int SLOT_BYTES_DEF = 512;

	// Depth of the command queue between front and back.
	localparam int FQ_DEPTH = 2;
	localparam int FQ_PTR_W = 1;

	// Command codes.
	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP = 2'd1;
	localparam logic [1:0] ACT_CHECK = 2'd2;
	localparam logic [1:0] ACT_FLUSH = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_PUSHED = 3'd0;
	localparam logic [2:0] ST_REJECTED = 3'd1;
	localparam logic [2:0] ST_POP_DATA = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_DEPTH = 3'd4;
	localparam logic [2:0] ST_FLUSHED = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_MAX_FRAME = 1'b0;
	localparam logic CFG_ENTRIES = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [9:0] MAX_FRAME_RST = 10'd512;
	localparam logic [4:0] ENTRIES_RST = 5'd16;

	// One classified command as it travels from front to back.
	typedef struct packed {
		logic [1:0] action;
		logic [63:0] data;
		logic [3:0] nbytes;
		logic last;
		logic [9:0] pop_limit;
	} frq_item_t;

	// Mask that keeps the lowest n bytes of a word; eight or more keeps all.
	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

### sv/frame_ring_queue.sv
// Channel   Handshake              Payload
// command   start high, busy low   action, data_word, word_bytes, last_word, pop_limit
// config    cfg_write high         cfg_index, cfg_data
// result    done high, one cycle   status, out_word, out_bytes, out_last, frame_bytes,
//                                  queue_depth
//
// Push words, depth checks, flushes and pops of an empty ring are each carried out in the
// idle state, so a push stream runs at one word per cycle while no pop is running; a result
// passes through the command queue and the result register. A pop of a stored frame reads
// the length store first (S_POPLEN), then delivers one word per cycle from the frame store.
// busy rises only while the two-entry command queue is full behind a pop; reset clears
// all control state at once, and results cannot be stalled (done marks each for one cycle).
module frame_ring_queue #(
	parameter int QUEUE_SLOTS = frq_pkg::QUEUE_SLOTS_DEF,
	parameter int SLOT_BYTES = frq_pkg::SLOT_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic [63:0] data_word,
	input logic [3:0] word_bytes,
	input logic last_word,
	input logic [9:0] pop_limit,
	input logic cfg_write,
	input logic cfg_index,
	input logic [9:0] cfg_data,
	output logic done,
	output logic [2:0] status,
	output logic [63:0] out_word,
	output logic [3:0] out_bytes,
	output logic out_last,
	output logic [9:0] frame_bytes,
	output logic [4:0] queue_depth
);

	frq_pkg::frq_item_t item;
	logic avail;
	logic take;

	// Front end: accepts and classifies commands into a short queue.
	frq_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.data_word(data_word),
		.word_bytes(word_bytes),
		.last_word(last_word),
		.pop_limit(pop_limit),
		.item(item),
		.avail(avail),
		.take(take)
	);

	// Back end: carries out commands against the frame ring.
	frq_back #(
		.QUEUE_SLOTS(QUEUE_SLOTS),
		.SLOT_BYTES(SLOT_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.avail(avail),
		.take(take),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.out_word(out_word),
		.out_bytes(out_bytes),
		.out_last(out_last),
		.frame_bytes(frame_bytes),
		.queue_depth(queue_depth)
	);

endmodule

### sv/frq_ram.sv
module frq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/frq_front.sv
module frq_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic [63:0] data_word,
	input logic [3:0] word_bytes,
	input logic last_word,
	input logic [9:0] pop_limit,
	output frq_pkg::frq_item_t item,
	output logic avail,
	input logic take
);

	localparam int CNT_W = $clog2(frq_pkg::FQ_DEPTH + 1);

	frq_pkg::frq_item_t entry_q [frq_pkg::FQ_DEPTH];
	logic [frq_pkg::FQ_PTR_W-1:0] wptr_q;
	logic [frq_pkg::FQ_PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic accept;
	frq_pkg::frq_item_t cls;

	assign busy = (cnt_q == CNT_W'(frq_pkg::FQ_DEPTH));
	assign accept = start && !busy;
	assign avail = (cnt_q != '0);
	assign item = entry_q[rptr_q];

	// Classify the incoming command: work out the bytes a push word adds.
	always_comb begin
		cls.action = action;
		cls.data = data_word;
		cls.last = last_word;
		cls.pop_limit = pop_limit;
		if (!last_word) begin
			cls.nbytes = 4'd8;
		end else if (word_bytes > 4'd8) begin
			cls.nbytes = 4'd8;
		end else begin
			cls.nbytes = word_bytes;
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wptr_q <= wptr_q + frq_pkg::FQ_PTR_W'(1);
			end
			if (take) begin
				rptr_q <= rptr_q + frq_pkg::FQ_PTR_W'(1);
			end
			if (accept && !take) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (take && !accept) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

### sv/frq_back.sv
`include "frame_ring_queue_defines.svh"

module frq_back #(
	parameter int QUEUE_SLOTS = frq_pkg::QUEUE_SLOTS_DEF,
	parameter int SLOT_BYTES = frq_pkg::SLOT_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input frq_pkg::frq_item_t item,
	input logic avail,
	output logic take,
	input logic cfg_write,
	input logic cfg_index,
	input logic [9:0] cfg_data,
	output logic done,
	output logic [2:0] status,
	output logic [63:0] out_word,
	output logic [3:0] out_bytes,
	output logic out_last,
	output logic [9:0] frame_bytes,
	output logic [4:0] queue_depth
);

	localparam int SLOT_W = $clog2(QUEUE_SLOTS);
	localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
	localparam int SLOT_WORDS = (SLOT_BYTES + 7) / 8;
	localparam int WI_W = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
	localparam int FS_DEPTH = QUEUE_SLOTS << WI_W;
	localparam int FS_AW = $clog2(FS_DEPTH);
	localparam logic [9:0] SLOT_LIMIT = 10'(SLOT_BYTES);

	// Sequencer states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POPLEN = 2'd1;
	localparam logic [1:0] S_POPRUN = 2'd2;

	logic [1:0] state_q;
	logic [SLOT_W-1:0] wslot_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [SLOT_W-1:0] pslot_q;
	logic [CNT_W-1:0] count_q;
	logic [9:0] sofar_q;
	logic drop_q;
	logic inframe_q;
	logic [9:0] maxb_q;
	logic [4:0] entries_q;
	logic [9:0] lim_q;
	logic [9:0] rem_q;
	logic [9:0] nlen_q;
	logic [WI_W-1:0] wi_q;

	logic done_q;
	logic [2:0] status_q;
	logic [63:0] oword_q;
	logic [3:0] obytes_q;
	logic olast_q;
	logic [9:0] fbytes_q;
	logic [4:0] depth_q;

	logic [CNT_W-1:0] eff;
	logic [9:0] limit;
	logic full;
	logic [9:0] p_sofar;
	logic p_drop0;
	logic [9:0] p_total;
	logic p_over;
	logic p_drop1;
	logic [9:0] p_sofar1;
	logic p_commit;
	logic is_push;
	logic [SLOT_W-1:0] wslot_nx;
	logic [SLOT_W-1:0] rslot_nx;

	logic fs_we;
	logic [FS_AW-1:0] fs_waddr;
	logic [FS_AW-1:0] fs_raddr;
	logic [63:0] fs_rdata;
	logic len_we;
	logic [9:0] len_rdata;
	logic [9:0] len_clamp;
	logic [9:0] pop_n;
	logic [3:0] run_vb;
	logic run_last;

	// Slot count and frame limit in force.
	always_comb begin
		if (entries_q == 5'd0) begin
			eff = CNT_W'(1);
		end else if (32'(entries_q) > QUEUE_SLOTS) begin
			eff = CNT_W'(QUEUE_SLOTS);
		end else begin
			eff = CNT_W'(entries_q);
		end
		limit = (maxb_q > SLOT_LIMIT) ? SLOT_LIMIT : maxb_q;
	end

	assign full = (count_q >= eff);

	// Ring index advance, wrapping at the slot count in force.
	always_comb begin
		wslot_nx = ((CNT_W'(wslot_q) + CNT_W'(1)) >= eff) ? '0 : wslot_q + SLOT_W'(1);
		rslot_nx = ((CNT_W'(rslot_q) + CNT_W'(1)) >= eff) ? '0 : rslot_q + SLOT_W'(1);
	end

	assign take = (state_q == S_IDLE) && avail;
	assign is_push = (item.action == frq_pkg::ACT_PUSH);

	// Push word: running total, limit check and commit decision.
	always_comb begin
		p_sofar = inframe_q ? sofar_q : 10'd0;
		p_drop0 = inframe_q ? drop_q : full;
		p_total = p_sofar + 10'(item.nbytes);
		p_over = !p_drop0 && (p_total > limit);
		p_drop1 = p_drop0 || p_over;
		p_sofar1 = p_drop1 ? p_sofar : p_total;
		p_commit = !p_drop1 && (p_sofar1 != 10'd0) && !full;
	end

	assign fs_we = take && is_push && !p_drop1 && (item.nbytes != 4'd0);
	assign fs_waddr = {wslot_q, WI_W'(p_sofar >> 3)};
	assign len_we = take && is_push && item.last && p_commit;

	// Frame store read address: first word after the length, then one ahead.
	assign fs_raddr = (state_q == S_POPLEN) ? {rslot_q, WI_W'(0)} :
		{pslot_q, wi_q + WI_W'(1)};

	frq_ram #(
		.WIDTH(64),
		.DEPTH(FS_DEPTH)
	) u_frame_store (
		.clk(clk),
		.we(fs_we),
		.waddr(fs_waddr),
		.wdata(item.data & frq_pkg::byte_mask(item.nbytes)),
		.raddr(fs_raddr),
		.rdata(fs_rdata)
	);

	frq_ram #(
		.WIDTH(10),
		.DEPTH(QUEUE_SLOTS)
	) u_slot_length (
		.clk(clk),
		.we(len_we),
		.waddr(wslot_q),
		.wdata(p_sofar1),
		.raddr(rslot_q),
		.rdata(len_rdata)
	);

	// Pop length and per-word byte counts.
	always_comb begin
		len_clamp = (len_rdata > SLOT_LIMIT) ? SLOT_LIMIT : len_rdata;
		pop_n = (lim_q < len_clamp) ? lim_q : len_clamp;
		run_vb = (rem_q > 10'd8) ? 4'd8 : rem_q[3:0];
		run_last = (rem_q <= 10'd8);
	end

	// Sequencer, ring state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wslot_q <= '0;
			rslot_q <= '0;
			pslot_q <= '0;
			count_q <= '0;
			sofar_q <= '0;
			drop_q <= 1'b0;
			inframe_q <= 1'b0;
			maxb_q <= frq_pkg::MAX_FRAME_RST;
			entries_q <= frq_pkg::ENTRIES_RST;
			lim_q <= '0;
			rem_q <= '0;
			nlen_q <= '0;
			wi_q <= '0;
			done_q <= 1'b0;
			status_q <= '0;
			oword_q <= '0;
			obytes_q <= '0;
			olast_q <= 1'b0;
			fbytes_q <= '0;
			depth_q <= '0;
		end else begin
			done_q <= 1'b0;
			oword_q <= '0;
			obytes_q <= '0;
			olast_q <= 1'b1;
			fbytes_q <= '0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (item.action)
							frq_pkg::ACT_PUSH: begin
								if (item.last) begin
									done_q <= 1'b1;
									inframe_q <= 1'b0;
									drop_q <= 1'b0;
									sofar_q <= '0;
									if (p_commit) begin
										status_q <= frq_pkg::ST_PUSHED;
										fbytes_q <= p_sofar1;
										wslot_q <= wslot_nx;
										count_q <= count_q + CNT_W'(1);
										depth_q <= 5'(count_q + CNT_W'(1));
									end else begin
										status_q <= frq_pkg::ST_REJECTED;
										depth_q <= 5'(count_q);
									end
								end else begin
									inframe_q <= 1'b1;
									drop_q <= p_drop1;
									sofar_q <= p_sofar1;
								end
							end
							frq_pkg::ACT_POP: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
									status_q <= frq_pkg::ST_EMPTY;
									depth_q <= 5'(count_q);
								end else begin
									lim_q <= item.pop_limit;
									state_q <= S_POPLEN;
								end
							end
							frq_pkg::ACT_CHECK: begin
								done_q <= 1'b1;
								status_q <= frq_pkg::ST_DEPTH;
								depth_q <= 5'(count_q);
							end
							default: begin
								done_q <= 1'b1;
								status_q <= frq_pkg::ST_FLUSHED;
								depth_q <= '0;
								rslot_q <= wslot_q;
								count_q <= '0;
							end
						endcase
					end
				end
				S_POPLEN: begin
					// The oldest frame is consumed here, whatever the limit.
					rslot_q <= rslot_nx;
					pslot_q <= rslot_q;
					count_q <= count_q - CNT_W'(1);
					if (pop_n == 10'd0) begin
						done_q <= 1'b1;
						status_q <= frq_pkg::ST_POP_DATA;
						depth_q <= 5'(count_q - CNT_W'(1));
						state_q <= S_IDLE;
					end else begin
						rem_q <= pop_n;
						nlen_q <= pop_n;
						wi_q <= '0;
						state_q <= S_POPRUN;
					end
				end
				S_POPRUN: begin
					done_q <= 1'b1;
					status_q <= frq_pkg::ST_POP_DATA;
					oword_q <= fs_rdata & frq_pkg::byte_mask(run_vb);
					obytes_q <= run_vb;
					olast_q <= run_last;
					fbytes_q <= nlen_q;
					depth_q <= 5'(count_q);
					rem_q <= rem_q - 10'(run_vb);
					wi_q <= wi_q + WI_W'(1);
					if (run_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Register writes; changing the slot count empties the ring.
			if (cfg_write) begin
				case (cfg_index)
					frq_pkg::CFG_MAX_FRAME: begin
						maxb_q <= cfg_data;
					end
					default: begin
						entries_q <= cfg_data[4:0];
						wslot_q <= '0;
						rslot_q <= '0;
						count_q <= '0;
						if (inframe_q) begin
							drop_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign out_word = oword_q;
	assign out_bytes = obytes_q;
	assign out_last = olast_q;
	assign frame_bytes = fbytes_q;
	assign queue_depth = depth_q;

	// Ring bookkeeping stays inside the slots in force.
	`FRQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= eff)
	`FRQ_ASSERT_SAME(a_wslot_bound, 1'b1, CNT_W'(wslot_q) < eff)
	// Every cycle of a pop run delivers one word.
	`FRQ_ASSERT_NEXT(a_run_emits, state_q == S_POPRUN, done_q && status_q == frq_pkg::ST_POP_DATA)
	// A flush result leaves the ring empty.
	`FRQ_ASSERT_SAME(a_flush_empty, done_q && status_q == frq_pkg::ST_FLUSHED, count_q == '0)

endmodule

### bench/frame_ring_queue_tb.sv
module frame_ring_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = frq_pkg::QUEUE_SLOTS_DEF;
	localparam int SLOT_WORDS = (frq_pkg::SLOT_BYTES_DEF + 7) / 8;
	localparam int RANDOM_ITEMS = 440;
	localparam int PHASE_ITEMS = 60;
	localparam int DRAIN_CYCLES = 8;

	// One result as the block should present it.
	typedef struct packed {
		logic [2:0] status;
		logic [63:0] word;
		logic [3:0] nbytes;
		logic last;
		logic [9:0] fbytes;
		logic [4:0] depth;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = frq_pkg::ACT_CHECK;
	logic [63:0] data_word = '0;
	logic [3:0] word_bytes = 4'd8;
	logic last_word = 1'b0;
	logic [9:0] pop_limit = '0;
	logic cfg_write = 1'b0;
	logic cfg_index = frq_pkg::CFG_MAX_FRAME;
	logic [9:0] cfg_data = '0;
	logic done;
	logic [2:0] status;
	logic [63:0] out_word;
	logic [3:0] out_bytes;
	logic out_last;
	logic [9:0] frame_bytes;
	logic [4:0] queue_depth;

	// Results still owed by the block, oldest first.
	queue_result_t owed_results[$];
	int error_count = 0;
	int items_sent = 0;
	bit no_gaps = 1'b0;

	// Shadow copy of the ring and its control state.
	logic [63:0] ring_words [SLOTS][SLOT_WORDS];
	int ring_len [SLOTS];
	int wr_slot;
	int rd_slot;
	int stored;
	int open_bytes;
	bit open_dropping;
	bit frame_open;
	logic [9:0] max_frame_reg;
	logic [4:0] entries_reg;

	frame_ring_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.data_word(data_word),
		.word_bytes(word_bytes),
		.last_word(last_word),
		.pop_limit(pop_limit),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.out_word(out_word),
		.out_bytes(out_bytes),
		.out_last(out_last),
		.frame_bytes(frame_bytes),
		.queue_depth(queue_depth)
	);

	always #4 clk = ~clk;

	// Slots in force: a zero counts as one, anything above the ring size as the ring size.
	function automatic int ring_size();
		if (entries_reg == 0) return 1;
		if (entries_reg > SLOTS) return SLOTS;
		return int'(entries_reg);
	endfunction

	function automatic int frame_cap();
		return (max_frame_reg > frq_pkg::SLOT_BYTES_DEF) ? frq_pkg::SLOT_BYTES_DEF :
			int'(max_frame_reg);
	endfunction

	function automatic int next_slot(int s);
		return (s + 1 >= ring_size()) ? 0 : s + 1;
	endfunction

	function automatic logic [63:0] low_bytes(logic [63:0] w, int n);
		if (n >= 8) return w;
		return w & ((64'd1 << (8 * n)) - 64'd1);
	endfunction

	function automatic void owe_result(logic [2:0] st, logic [63:0] w, int nb, bit lst,
			int fb, int dep);
		queue_result_t r;
		r.status = st;
		r.word = w;
		r.nbytes = 4'(nb);
		r.last = lst;
		r.fbytes = 10'(fb);
		r.depth = 5'(dep);
		owed_results.push_back(r);
	endfunction

	function automatic void ring_reset();
		wr_slot = 0;
		rd_slot = 0;
		stored = 0;
		open_bytes = 0;
		open_dropping = 1'b0;
		frame_open = 1'b0;
		max_frame_reg = frq_pkg::MAX_FRAME_RST;
		entries_reg = frq_pkg::ENTRIES_RST;
	endfunction

	// A push word: the frame is judged at its first word and committed at its last.
	function automatic void ring_push(logic [63:0] w, logic [3:0] wb, logic lst);
		int b;
		int total;
		if (!frame_open) begin
			frame_open = 1'b1;
			open_bytes = 0;
			open_dropping = (stored >= ring_size());
		end
		b = !lst ? 8 : ((wb > 8) ? 8 : int'(wb));
		if (!open_dropping) begin
			total = open_bytes + b;
			if (total > frame_cap()) begin
				open_dropping = 1'b1;
			end else begin
				if (b > 0) ring_words[wr_slot][open_bytes / 8] = low_bytes(w, b);
				open_bytes = total;
			end
		end
		if (!lst) return;
		frame_open = 1'b0;
		if (open_dropping || open_bytes == 0 || stored >= ring_size()) begin
			open_dropping = 1'b0;
			open_bytes = 0;
			owe_result(frq_pkg::ST_REJECTED, '0, 0, 1'b1, 0, stored);
		end else begin
			ring_len[wr_slot] = open_bytes;
			wr_slot = next_slot(wr_slot);
			stored++;
			owe_result(frq_pkg::ST_PUSHED, '0, 0, 1'b1, open_bytes, stored);
			open_bytes = 0;
		end
	endfunction

	// A pop: the oldest frame, cut to the limit, one result per word.
	function automatic void ring_pop(logic [9:0] limit);
		int slot;
		int n;
		int words;
		int rem;
		int vb;
		if (stored == 0) begin
			owe_result(frq_pkg::ST_EMPTY, '0, 0, 1'b1, 0, stored);
			return;
		end
		slot = rd_slot;
		n = (int'(limit) < ring_len[slot]) ? int'(limit) : ring_len[slot];
		rd_slot = next_slot(rd_slot);
		stored--;
		if (n == 0) begin
			owe_result(frq_pkg::ST_POP_DATA, '0, 0, 1'b1, 0, stored);
			return;
		end
		words = (n + 7) / 8;
		for (int i = 0; i < words; i++) begin
			rem = n - 8 * i;
			vb = (rem > 8) ? 8 : rem;
			owe_result(frq_pkg::ST_POP_DATA, low_bytes(ring_words[slot][i], vb), vb,
				i + 1 == words, n, stored);
		end
	endfunction

	function automatic void ring_command(logic [1:0] act, logic [63:0] w, logic [3:0] wb,
			logic lst, logic [9:0] limit);
		case (act)
			frq_pkg::ACT_PUSH: ring_push(w, wb, lst);
			frq_pkg::ACT_POP: ring_pop(limit);
			frq_pkg::ACT_CHECK: owe_result(frq_pkg::ST_DEPTH, '0, 0, 1'b1, 0, stored);
			default: begin
				rd_slot = wr_slot;
				stored = 0;
				owe_result(frq_pkg::ST_FLUSHED, '0, 0, 1'b1, 0, 0);
			end
		endcase
	endfunction

	// Register writes; a new ring size empties the ring and spoils an open frame.
	function automatic void ring_register(logic idx, logic [9:0] val);
		if (idx == frq_pkg::CFG_MAX_FRAME) begin
			max_frame_reg = val;
		end else begin
			entries_reg = val[4:0];
			wr_slot = 0;
			rd_slot = 0;
			stored = 0;
			if (frame_open) open_dropping = 1'b1;
		end
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		if (error_count <= 40)
			$display("MISMATCH %s: got %0h, wanted %0h at %0t ns", what, got, want, $realtime);
	endtask

	// Every strobed result is one transfer; match it against the oldest owed result.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				report_mismatch("result with nothing owed", status, '0);
			end else begin
				want = owed_results.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (out_word !== want.word) report_mismatch("out_word", out_word, want.word);
				if (out_bytes !== want.nbytes)
					report_mismatch("out_bytes", out_bytes, want.nbytes);
				if (out_last !== want.last) report_mismatch("out_last", out_last, want.last);
				if (frame_bytes !== want.fbytes)
					report_mismatch("frame_bytes", frame_bytes, want.fbytes);
				if (queue_depth !== want.depth)
					report_mismatch("queue_depth", queue_depth, want.depth);
			end
		end
	end

	// Offer one command and hold it until the block takes it; start is left high.
	task automatic send_command(logic [1:0] act, logic [63:0] w, logic [3:0] wb, logic lst,
			logic [9:0] limit);
		start <= 1'b1;
		action <= act;
		data_word <= w;
		word_bytes <= wb;
		last_word <= lst;
		pop_limit <= limit;
		@(posedge clk);
		while (busy) @(posedge clk);
		ring_command(act, w, wb, lst, limit);
		items_sent++;
	endtask

	// Random gaps between commands unless a steady stretch is running.
	task automatic pace();
		if (!no_gaps) begin
			while ($urandom_range(0, 99) < 37) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Stop sending, wait for every owed result, then let a trailing push word settle.
	task automatic settle();
		start <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [9:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_write <= 1'b1;
		@(posedge clk);
		ring_register(idx, val);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// A frame of random bytes; the middle words may carry junk byte counts.
	task automatic push_frame(int nwords, logic [3:0] last_bytes, bit interleave);
		logic [3:0] wb;
		for (int i = 0; i < nwords; i++) begin
			if (i == nwords - 1) begin
				send_command(frq_pkg::ACT_PUSH, rand_word(), last_bytes, 1'b1, 10'($urandom));
			end else begin
				wb = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd8;
				send_command(frq_pkg::ACT_PUSH, rand_word(), wb, 1'b0, 10'($urandom));
			end
			pace();
			if (interleave && $urandom_range(0, 99) < 4) begin
				send_command($urandom_range(0, 1) ? frq_pkg::ACT_POP : frq_pkg::ACT_CHECK,
					rand_word(), 4'd8, 1'b0, 10'($urandom));
				pace();
			end
		end
	endtask

	// Check, pop and flush on a queue that holds nothing.
	task automatic test_empty_queue();
		send_command(frq_pkg::ACT_CHECK, '0, 4'd0, 1'b0, 10'd0);
		send_command(frq_pkg::ACT_POP, '1, 4'hF, 1'b1, 10'h3FF);
		send_command(frq_pkg::ACT_FLUSH, '0, 4'd0, 1'b0, 10'd0);
	endtask

	// One-word frames: full word, oversized byte count, empty frame; pops at both limits.
	task automatic test_single_word_frames();
		send_command(frq_pkg::ACT_PUSH, '1, 4'd8, 1'b1, 10'd0);
		send_command(frq_pkg::ACT_PUSH, '0, 4'hF, 1'b1, 10'h3FF);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd0, 1'b1, 10'd0);
		send_command(frq_pkg::ACT_POP, '0, 4'd0, 1'b0, 10'h3FF);
		send_command(frq_pkg::ACT_POP, '0, 4'd0, 1'b0, 10'd0);
	endtask

	// Multi-word frames, a flush in the middle of a push, and a truncating pop.
	task automatic test_multi_word_frames();
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd0, 1'b0, 10'd0);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'hF, 1'b0, 10'd0);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'hF, 1'b1, 10'd0);
		send_command(frq_pkg::ACT_POP, '0, 4'd0, 1'b0, 10'h3FF);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd8, 1'b0, 10'd0);
		send_command(frq_pkg::ACT_FLUSH, '0, 4'd0, 1'b0, 10'd0);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd3, 1'b1, 10'd0);
		send_command(frq_pkg::ACT_POP, '0, 4'd0, 1'b0, 10'd5);
	endtask

	// Frame limit: oversize frames, the smallest limits and a limit above the slot size.
	task automatic test_frame_limit();
		settle();
		write_reg(frq_pkg::CFG_MAX_FRAME, 10'd16);
		push_frame(3, 4'd8, 1'b0);
		settle();
		write_reg(frq_pkg::CFG_MAX_FRAME, 10'd1);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd1, 1'b1, 10'd0);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd2, 1'b1, 10'd0);
		settle();
		write_reg(frq_pkg::CFG_MAX_FRAME, 10'd0);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd1, 1'b1, 10'd0);
		settle();
		write_reg(frq_pkg::CFG_MAX_FRAME, 10'h3FF);
		send_command(frq_pkg::ACT_POP, '0, 4'd0, 1'b0, 10'h3FF);
	endtask

	// Ring size: a zero size holds one frame, and a size change drops an open frame.
	task automatic test_ring_size();
		settle();
		write_reg(frq_pkg::CFG_ENTRIES, 10'h3E0);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd8, 1'b1, 10'd0);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd8, 1'b1, 10'd0);
		send_command(frq_pkg::ACT_POP, '0, 4'd0, 1'b0, 10'd512);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd8, 1'b0, 10'd0);
		settle();
		write_reg(frq_pkg::CFG_ENTRIES, 10'd31);
		send_command(frq_pkg::ACT_PUSH, rand_word(), 4'd8, 1'b1, 10'd0);
	endtask

	function automatic logic [9:0] pick_max_frame();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 10'd512;
		if (r < 75) return 10'($urandom_range(1, 512));
		if (r < 85) return 10'($urandom_range(513, 1023));
		if (r < 95) return 10'($urandom_range(1, 24));
		return 10'd0;
	endfunction

	function automatic logic [9:0] pick_entries();
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		if (r < 60) n = $urandom_range(1, 4);
		else if (r < 85) n = $urandom_range(5, 16);
		else n = $urandom_range(0, 31);
		return {5'($urandom), 5'(n)};
	endfunction

	// One phase of mixed traffic, mostly whole frames and pops.
	task automatic run_phase(int count);
		int first;
		int unsigned r;
		int nwords;
		logic [3:0] last_bytes;
		logic [9:0] limit;
		first = items_sent;
		while (items_sent - first < count) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				r = $urandom_range(0, 99);
				if (r < 80) nwords = $urandom_range(1, 4);
				else if (r < 95) nwords = $urandom_range(5, 20);
				else nwords = $urandom_range(62, 66);
				last_bytes = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8)) :
					4'($urandom);
				push_frame(nwords, last_bytes, 1'b1);
			end else if (r < 80) begin
				r = $urandom_range(0, 99);
				if (r < 40) limit = 10'($urandom);
				else if (r < 90) limit = 10'd512;
				else limit = 10'($urandom_range(0, 16));
				send_command(frq_pkg::ACT_POP, rand_word(), 4'($urandom), 1'($urandom), limit);
				pace();
			end else if (r < 88) begin
				send_command(frq_pkg::ACT_CHECK, rand_word(), 4'($urandom), 1'($urandom),
					10'($urandom));
				pace();
			end else if (r < 92) begin
				send_command(frq_pkg::ACT_FLUSH, rand_word(), 4'($urandom), 1'($urandom),
					10'($urandom));
				pace();
			end else begin
				send_command(2'($urandom), rand_word(), 4'($urandom), 1'($urandom),
					10'($urandom));
				pace();
			end
		end
	endtask

	// Random traffic in phases, with new register settings between phases.
	task automatic test_random_traffic();
		int target;
		int phase;
		int chunk;
		target = items_sent + RANDOM_ITEMS;
		phase = 0;
		while (items_sent < target) begin
			settle();
			write_reg(frq_pkg::CFG_MAX_FRAME, pick_max_frame());
			if (phase == 0 || $urandom_range(0, 99) < 70) begin
				write_reg(frq_pkg::CFG_ENTRIES, pick_entries());
			end
			no_gaps = (phase == 2);
			// The last phase only tops up to the item budget.
			chunk = target - items_sent;
			if (chunk > PHASE_ITEMS) chunk = PHASE_ITEMS;
			run_phase(chunk);
			phase++;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		ring_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_single_word_frames();
		test_multi_word_frames();
		test_frame_limit();
		test_ring_size();
		test_random_traffic();
		settle();
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/frq_pkg.sv
sv/frq_ram.sv
sv/frq_front.sv
sv/frq_back.sv
sv/frame_ring_queue.sv
bench/frame_ring_queue_tb.sv
